// ===== hw/rtl/bti_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and constants of the bilinear table interpolator: payload
// structs, function codes, and the command/status bundle between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bti_pkg;

    localparam int COORD_W     = 48;  // grid and query coordinate width
    localparam int VAL_W       = 32;  // Q16.16 table value width
    localparam int D_IDX_W     = 7;
    localparam int T_IDX_W     = 7;
    localparam int MAX_D       = 128;
    localparam int MAX_T       = 128;
    localparam int PTS_W       = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int TAB_ADDR_W  = D_IDX_W + T_IDX_W;

    localparam logic [PTS_W-1:0] D_PTS_RESET = 8'd99;
    localparam logic [PTS_W-1:0] T_PTS_RESET = 8'd92;

    // lerp unit: magnitude x coordinate, multiplied in chunks, divided bit-serially
    localparam int MAG_W      = VAL_W + 1;
    localparam int MUL_CHUNK  = 16;
    localparam int MUL_STEPS  = COORD_W / MUL_CHUNK;
    localparam int PROD_W     = MAG_W + COORD_W;
    localparam int QUOT_W     = MAG_W;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int CNT_W      = 6;

    typedef enum logic [1:0] {
        FN_WR_DENSITY = 2'd0,
        FN_WR_TEMP    = 2'd1,
        FN_WR_TABLE   = 2'd2,
        FN_QUERY      = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DENSITY_POINTS = 1'b0,
        CFG_TEMP_POINTS    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_func                     func;
        logic [D_IDX_W-1:0]        density_index;
        logic [T_IDX_W-1:0]        temperature_index;
        logic [COORD_W-1:0]        grid_value;
        logic signed [VAL_W-1:0]   table_value;
        logic [COORD_W-1:0]        query_density;
        logic [COORD_W-1:0]        query_temperature;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]   result_value;
        logic                      density_low_clamped;
        logic                      density_high_clamped;
        logic                      temperature_low_clamped;
        logic                      temperature_high_clamped;
        logic                      grid_error;
    } t_out_item;

    // grid read address select
    typedef enum logic [2:0] {
        RS_FIRST, RS_LAST, RS_MID, RS_LO, RS_HI
    } t_rsel;

    // table read address select: {row t or t+1, column d or d+1}
    typedef enum logic [1:0] {
        TS_00, TS_01, TS_10, TS_11
    } t_tsel;

    // what to capture from read data this cycle
    typedef enum logic [2:0] {
        CAP_NONE, CAP_FIRST, CAP_LAST, CAP_BIS, CAP_LOW, CAP_HIGH, CAP_T10, CAP_T11
    } t_cap;

    typedef enum logic [2:0] {
        LOP_NONE, LOP_LOAD, LOP_CHECK, LOP_PREP, LOP_MUL, LOP_DINIT, LOP_DIV, LOP_END
    } t_lop;

    typedef enum logic [1:0] {
        LS_ROW0, LS_ROW1, LS_TEMP
    } t_lsel;

    typedef struct packed {
        logic   write_item;
        logic   load_query;
        t_rsel  rsel;
        t_tsel  tsel;
        t_cap   cap;
        logic   fix_low;
        logic   fix_high;
        t_lop   lop;
        t_lsel  lsel;
        logic   out_en;
    } t_cmd;

    typedef struct packed {
        logic   bis_done;
    } t_status;

endpackage
`default_nettype wire

// ===== hw/rtl/bti_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bti_ctrl
// Item sequencer: write strobes; for queries edge reads, bisection loop, bracket
// fix-up and reads, then three interpolation passes through the shared lerp unit.
// ----------------------------------------------------------------------------
module bti_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire bti_pkg::t_func  i_func,
    input  wire bti_pkg::t_status i_status,
    output bti_pkg::t_cmd        o_cmd,
    output logic                 o_busy,
    output logic                 o_done
);
    import bti_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_FIRST, S_LAST, S_BWAIT, S_BADDR, S_BCMP, S_FIX_LOW, S_FIX_HIGH,
        S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
        S_LOAD, S_CHECK, S_PREP, S_MUL, S_DINIT, S_DIV, S_END, S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    t_lsel            r_lsel;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_lsel  <= LS_ROW0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && i_func == FN_QUERY) r_state <= S_FIRST;
                end
                S_FIRST:   r_state <= S_LAST;
                S_LAST:    r_state <= S_BWAIT;
                S_BWAIT:   r_state <= S_BADDR;
                S_BADDR: begin
                    if (i_status.bis_done) r_state <= S_FIX_LOW;
                    else                   r_state <= S_BCMP;
                end
                S_BCMP:     r_state <= S_BADDR;
                S_FIX_LOW:  r_state <= S_FIX_HIGH;
                S_FIX_HIGH: r_state <= S_RD0;
                S_RD0:      r_state <= S_RD1;
                S_RD1:      r_state <= S_RD2;
                S_RD2:      r_state <= S_RD3;
                S_RD3:      r_state <= S_RD4;
                S_RD4: begin
                    r_lsel  <= LS_ROW0;
                    r_state <= S_LOAD;
                end
                S_LOAD:  r_state <= S_CHECK;
                S_CHECK: r_state <= S_PREP;
                S_PREP: begin
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DINIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DINIT: r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_END;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_END: begin
                    unique case (r_lsel)
                        LS_ROW0: begin
                            r_lsel  <= LS_ROW1;
                            r_state <= S_LOAD;
                        end
                        LS_ROW1: begin
                            r_lsel  <= LS_TEMP;
                            r_state <= S_LOAD;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.rsel       = RS_FIRST;
        o_cmd.tsel       = TS_00;
        o_cmd.cap        = CAP_NONE;
        o_cmd.lop        = LOP_NONE;
        o_cmd.lsel       = r_lsel;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.write_item = i_start && (i_func != FN_QUERY);
                o_cmd.load_query = i_start && (i_func == FN_QUERY);
            end
            S_FIRST:    o_cmd.rsel = RS_FIRST;
            S_LAST: begin
                o_cmd.rsel = RS_LAST;
                o_cmd.cap  = CAP_FIRST;
            end
            S_BWAIT:    o_cmd.cap = CAP_LAST;
            S_BADDR:    o_cmd.rsel = RS_MID;
            S_BCMP:     o_cmd.cap = CAP_BIS;
            S_FIX_LOW:  o_cmd.fix_low = 1'b1;
            S_FIX_HIGH: o_cmd.fix_high = 1'b1;
            S_RD0: begin
                o_cmd.rsel = RS_LO;
                o_cmd.tsel = TS_00;
            end
            S_RD1: begin
                o_cmd.cap  = CAP_LOW;
                o_cmd.rsel = RS_HI;
                o_cmd.tsel = TS_01;
            end
            S_RD2: begin
                o_cmd.cap  = CAP_HIGH;
                o_cmd.tsel = TS_10;
            end
            S_RD3: begin
                o_cmd.cap  = CAP_T10;
                o_cmd.tsel = TS_11;
            end
            S_RD4:   o_cmd.cap = CAP_T11;
            S_LOAD:  o_cmd.lop = LOP_LOAD;
            S_CHECK: o_cmd.lop = LOP_CHECK;
            S_PREP:  o_cmd.lop = LOP_PREP;
            S_MUL:   o_cmd.lop = LOP_MUL;
            S_DINIT: o_cmd.lop = LOP_DINIT;
            S_DIV:   o_cmd.lop = LOP_DIV;
            S_END:   o_cmd.lop = LOP_END;
            S_OUT:   o_cmd.out_en = 1'b1;
            default: o_cmd.out_en = 1'b0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== hw/rtl/bti_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bti_datapath
// Grid and table memories, point-count registers, bisection registers,
// bracket fix-up and the shared multiply/divide lerp unit.
// ----------------------------------------------------------------------------
module bti_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bti_pkg::t_in_item             i_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [bti_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bti_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire bti_pkg::t_cmd                 i_cmd,
    output bti_pkg::t_status                   o_status,
    output bti_pkg::t_out_item                 o_result
);
    import bti_pkg::*;

    localparam logic [PTS_W-1:0] MAX_D_PTS = PTS_W'(MAX_D);
    localparam logic [PTS_W-1:0] MAX_T_PTS = PTS_W'(MAX_T);
    localparam int PP_W = MAG_W + MUL_CHUNK;

    function automatic logic [PTS_W-1:0] fit_points(input logic [PTS_W-1:0] v,
                                                    input logic [PTS_W-1:0] mx);
        logic [PTS_W-1:0] r;
        r = v;
        if (v < 8'd2) r = 8'd2;
        if (v > mx)   r = mx;
        return r;
    endfunction

    // configuration
    logic [PTS_W-1:0] r_d_pts, r_t_pts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_pts <= D_PTS_RESET;
            r_t_pts <= T_PTS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DENSITY_POINTS: r_d_pts <= i_cfg_data;
                CFG_TEMP_POINTS:    r_t_pts <= i_cfg_data;
                default:            r_d_pts <= r_d_pts;
            endcase
        end
    end

    // memories
    logic [COORD_W-1:0] r_dgrid_mem [MAX_D];
    logic [COORD_W-1:0] r_tgrid_mem [MAX_T];
    logic [VAL_W-1:0]   r_tab_mem   [MAX_D*MAX_T];
    logic [COORD_W-1:0] r_dg_q, r_tg_q;
    logic [VAL_W-1:0]   r_tab_q;
    logic [D_IDX_W-1:0] dg_addr;
    logic [T_IDX_W-1:0] tg_addr;
    logic [TAB_ADDR_W-1:0] tab_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_item && i_item.func == FN_WR_DENSITY)
            r_dgrid_mem[i_item.density_index] <= i_item.grid_value;
        r_dg_q <= r_dgrid_mem[dg_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_item && i_item.func == FN_WR_TEMP)
            r_tgrid_mem[i_item.temperature_index] <= i_item.grid_value;
        r_tg_q <= r_tgrid_mem[tg_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_item && i_item.func == FN_WR_TABLE)
            r_tab_mem[{i_item.temperature_index, i_item.density_index}] <= i_item.table_value;
        r_tab_q <= r_tab_mem[tab_addr];
    end

    // query state
    logic [COORD_W-1:0] r_xq, r_yq;
    logic [PTS_W-1:0]   r_nd, r_nt;
    logic [COORD_W-1:0] r_dg0, r_dgl, r_tg0, r_tgl;
    logic [PTS_W-1:0]   r_d_lo1, r_d_hi, r_t_lo1, r_t_hi;  // lo1 = lower bracket + 1
    logic [D_IDX_W-1:0] r_d;
    logic [T_IDX_W-1:0] r_t;
    logic               r_dlo, r_dhi, r_tlo, r_thi, r_err;

    logic [PTS_W-1:0]   nd_m1, nt_m1;
    logic [PTS_W:0]     d_sum, t_sum;
    logic [D_IDX_W-1:0] m_d;
    logic [T_IDX_W-1:0] m_t;
    logic               d_run, t_run;

    assign nd_m1 = r_nd - 8'd1;
    assign nt_m1 = r_nt - 8'd1;
    assign d_sum = {1'b0, r_d_lo1} + {1'b0, r_d_hi} - 9'd1;
    assign t_sum = {1'b0, r_t_lo1} + {1'b0, r_t_hi} - 9'd1;
    assign m_d   = d_sum[D_IDX_W:1];
    assign m_t   = t_sum[T_IDX_W:1];
    assign d_run = r_d_hi > r_d_lo1;
    assign t_run = r_t_hi > r_t_lo1;
    assign o_status.bis_done = !d_run && !t_run;

    always_comb begin
        unique case (i_cmd.rsel)
            RS_FIRST: begin dg_addr = '0;                tg_addr = '0; end
            RS_LAST:  begin dg_addr = nd_m1[D_IDX_W-1:0]; tg_addr = nt_m1[T_IDX_W-1:0]; end
            RS_MID:   begin dg_addr = m_d;               tg_addr = m_t; end
            RS_LO:    begin dg_addr = r_d;               tg_addr = r_t; end
            RS_HI:    begin dg_addr = r_d + 1'b1;        tg_addr = r_t + 1'b1; end
            default:  begin dg_addr = '0;                tg_addr = '0; end
        endcase
        unique case (i_cmd.tsel)
            TS_00:   tab_addr = {r_t, r_d};
            TS_01:   tab_addr = {r_t, r_d + 1'b1};
            TS_10:   tab_addr = {r_t + 1'b1, r_d};
            default: tab_addr = {r_t + 1'b1, r_d + 1'b1};
        endcase
    end

    // bracket fix-ups: equality snaps and low clamps, then high clamps and fit
    logic [PTS_W-1:0] fl_d_lo1, fl_t_lo1, fh_d_lo1, fh_t_lo1;
    logic [PTS_W-1:0] d_fit, t_fit;

    always_comb begin
        fl_d_lo1 = r_d_lo1;
        if (r_xq == r_dgl) fl_d_lo1 = nd_m1;
        if (r_xq == r_dg0) fl_d_lo1 = 8'd1;
        if (r_xq <  r_dgl) fl_d_lo1 = nd_m1;
        fl_t_lo1 = r_t_lo1;
        if (r_yq == r_tgl) fl_t_lo1 = nt_m1;
        if (r_yq == r_tg0) fl_t_lo1 = 8'd1;
        if (r_yq <  r_tg0) fl_t_lo1 = 8'd1;

        fh_d_lo1 = r_d_lo1;
        if (r_xq > r_dg0) fh_d_lo1 = 8'd1;
        fh_t_lo1 = r_t_lo1;
        if (r_yq > r_tgl) fh_t_lo1 = nt_m1;

        d_fit = fh_d_lo1;
        if (d_fit == 8'd0) d_fit = 8'd1;
        if (d_fit > nd_m1) d_fit = nd_m1;
        t_fit = fh_t_lo1;
        if (t_fit == 8'd0) t_fit = 8'd1;
        if (t_fit > nt_m1) t_fit = nt_m1;
    end

    // bracket operands
    logic [COORD_W-1:0]      r_dx0, r_dx1, r_tx0, r_tx1;
    logic signed [VAL_W-1:0] r_v00, r_v01, r_v10, r_v11;  // v[t][d], v[t][d+1], ...

    // lerp unit
    logic [COORD_W-1:0]      r_lx0, r_lx1, r_lx, r_dx, r_den, r_rem;
    logic signed [VAL_W-1:0] r_lv0, r_lv1, r_r0, r_r1, r_rv;
    logic signed [MAG_W-1:0] r_ldiff;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_acc;
    logic [QUOT_W-1:0]       r_low;

    logic [PP_W-1:0]         pp;
    logic [COORD_W:0]        trial, trial_sub;
    logic                    qbit;
    logic signed [MAG_W:0]   lres;

    assign pp        = PP_W'(r_mag) * PP_W'(r_dx[COORD_W-1 -: MUL_CHUNK]);
    assign trial     = {r_rem, r_low[QUOT_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign qbit      = trial >= {1'b0, r_den};
    assign lres      = r_neg ? ((MAG_W+1)'(r_lv0) - {1'b0, r_low})
                             : ((MAG_W+1)'(r_lv0) + {1'b0, r_low});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_xq    <= i_item.query_density;
            r_yq    <= i_item.query_temperature;
            r_nd    <= fit_points(r_d_pts, MAX_D_PTS);
            r_nt    <= fit_points(r_t_pts, MAX_T_PTS);
            r_d_lo1 <= '0;
            r_t_lo1 <= '0;
            r_d_hi  <= fit_points(r_d_pts, MAX_D_PTS);
            r_t_hi  <= fit_points(r_t_pts, MAX_T_PTS);
            r_dlo   <= 1'b0;
            r_dhi   <= 1'b0;
            r_tlo   <= 1'b0;
            r_thi   <= 1'b0;
            r_err   <= 1'b0;
        end

        unique case (i_cmd.cap)
            CAP_FIRST: begin r_dg0 <= r_dg_q; r_tg0 <= r_tg_q; end
            CAP_LAST:  begin r_dgl <= r_dg_q; r_tgl <= r_tg_q; end
            CAP_BIS: begin
                if (d_run) begin
                    if (r_xq < r_dg_q) r_d_lo1 <= {1'b0, m_d} + 8'd1;
                    else               r_d_hi  <= {1'b0, m_d};
                end
                if (t_run) begin
                    if (r_yq >= r_tg_q) r_t_lo1 <= {1'b0, m_t} + 8'd1;
                    else                r_t_hi  <= {1'b0, m_t};
                end
            end
            CAP_LOW:  begin r_dx1 <= r_dg_q; r_tx0 <= r_tg_q; r_v00 <= r_tab_q; end
            CAP_HIGH: begin r_dx0 <= r_dg_q; r_tx1 <= r_tg_q; r_v01 <= r_tab_q; end
            CAP_T10:  r_v10 <= r_tab_q;
            CAP_T11:  r_v11 <= r_tab_q;
            default:  ;
        endcase

        if (i_cmd.fix_low) begin
            r_d_lo1 <= fl_d_lo1;
            r_t_lo1 <= fl_t_lo1;
            if (r_xq < r_dgl) begin
                r_dlo <= 1'b1;
                r_xq  <= r_dgl;
            end
            if (r_yq < r_tg0) begin
                r_tlo <= 1'b1;
                r_yq  <= r_tg0;
            end
        end

        if (i_cmd.fix_high) begin
            if (r_xq > r_dg0) begin
                r_dhi <= 1'b1;
                r_xq  <= r_dg0;
            end
            if (r_yq > r_tgl) begin
                r_thi <= 1'b1;
                r_yq  <= r_tgl;
            end
            r_d <= D_IDX_W'(d_fit - 8'd1);
            r_t <= T_IDX_W'(t_fit - 8'd1);
        end

        unique case (i_cmd.lop)
            LOP_LOAD: begin
                unique case (i_cmd.lsel)
                    LS_ROW0: begin
                        r_lx0 <= r_dx0; r_lx1 <= r_dx1; r_lx <= r_xq;
                        r_lv0 <= r_v01; r_lv1 <= r_v00;
                    end
                    LS_ROW1: begin
                        r_lx0 <= r_dx0; r_lx1 <= r_dx1; r_lx <= r_xq;
                        r_lv0 <= r_v11; r_lv1 <= r_v10;
                    end
                    default: begin
                        r_lx0 <= r_tx0; r_lx1 <= r_tx1; r_lx <= r_yq;
                        r_lv0 <= r_r0;  r_lv1 <= r_r1;
                    end
                endcase
            end
            LOP_CHECK: begin
                if (r_lx0 >= r_lx1) r_err <= 1'b1;
                if (r_lx < r_lx0)      r_lx <= r_lx0;
                else if (r_lx > r_lx1) r_lx <= r_lx1;
                r_ldiff <= MAG_W'(r_lv1) - MAG_W'(r_lv0);
            end
            LOP_PREP: begin
                r_dx  <= r_lx - r_lx0;
                r_den <= r_lx1 - r_lx0;
                r_neg <= r_ldiff[MAG_W-1];
                r_mag <= r_ldiff[MAG_W-1] ? MAG_W'(-r_ldiff) : MAG_W'(r_ldiff);
                r_acc <= '0;
            end
            LOP_MUL: begin
                r_acc <= {r_acc[PROD_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}} + PROD_W'(pp);
                r_dx  <= {r_dx[COORD_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}};
            end
            LOP_DINIT: begin
                r_rem <= r_acc[PROD_W-1 -: COORD_W];
                r_low <= r_acc[QUOT_W-1:0];
            end
            LOP_DIV: begin
                r_rem <= qbit ? trial_sub[COORD_W-1:0] : trial[COORD_W-1:0];
                r_low <= {r_low[QUOT_W-2:0], qbit};
            end
            LOP_END: begin
                unique case (i_cmd.lsel)
                    LS_ROW0: r_r0 <= VAL_W'(lres);
                    LS_ROW1: r_r1 <= VAL_W'(lres);
                    default: r_rv <= VAL_W'(lres);
                endcase
            end
            default: ;
        endcase
    end

    // result register
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            r_out.result_value             <= r_err ? '0 : r_rv;
            r_out.density_low_clamped      <= r_dlo;
            r_out.density_high_clamped     <= r_dhi;
            r_out.temperature_low_clamped  <= r_tlo;
            r_out.temperature_high_clamped <= r_thi;
            r_out.grid_error               <= r_err;
        end
    end

    assign o_result = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/bilinear_table_interpolator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// Two-dimensional Q16.16 table lookup with bilinear interpolation over a
// descending density grid and an ascending temperature grid.
// ----------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; the item is taken on
// that edge. Grid and table writes complete on that edge and leave busy
// low, so writes may follow back to back. A query raises busy; its result
// appears on o_result when o_done rises, and o_done is high for exactly
// one cycle; the receiver has no way to hold it, so it must capture it
// then. A query fetches the first and last grid entries, runs the
// bisection loop on both grids (memory read then compare per step) until
// both brackets close, applies the bracket fix-up (low, then high), reads
// the bracket grid and table entries, and makes three interpolation
// passes. Each pass is dominated by the bit-serial divider (33 steps),
// after a chunked 33x16 multiply. A new item may be accepted in the cycle
// o_done is high. The user must write the point-count registers through
// the plain config port only while idle; the block itself does not
// enforce it. Counts below 2 act as 2, above 128 act as 128. Grid and
// table entries hold nothing useful until written.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire bti_pkg::t_in_item             i_item,
    output logic                               o_done,
    output bti_pkg::t_out_item                 o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [bti_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bti_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bti_pkg::*;

    t_cmd    cmd;     // controller to datapath
    t_status status;  // bisection convergence

    bti_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_item.func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    bti_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire
